[hdl/tdss_pkg.sv]
`default_nettype none
package tdss_pkg;
	localparam int MaxRows = 64;
	localparam int RhsLanes = 4;
	localparam int FracBits = 16;
	localparam int RowW = $clog2(MaxRows);
	localparam int LaneW = $clog2(RhsLanes);
	localparam int DivCycles = 32 + FracBits + 2;

	localparam logic [0:0] RegRowCount = 1'd0;
	localparam logic [0:0] RegRhsCount = 1'd1;

	typedef logic signed [31:0] fx_t;
	typedef fx_t [RhsLanes-1:0] lanes_t;

	function automatic fx_t sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		else if (v < -66'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	// product shifted right arithmetically floors toward minus infinity
	function automatic fx_t fx_mul(input fx_t a, input fx_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32(66'(p >>> FracBits));
	endfunction

	function automatic fx_t fx_sub(input fx_t a, input fx_t b);
		return sat32(66'(a) - 66'(b));
	endfunction
endpackage
`default_nettype wire

[hdl/tdss_if.sv]
`default_nettype none
interface tdss_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] sub_diag;
	logic signed [31:0] main_diag;
	logic signed [31:0] super_diag;
	logic signed [31:0] rhs_lane0;
	logic signed [31:0] rhs_lane1;
	logic signed [31:0] rhs_lane2;
	logic signed [31:0] rhs_lane3;
	modport source(output valid, sub_diag, main_diag, super_diag, rhs_lane0, rhs_lane1,
		rhs_lane2, rhs_lane3, input ready);
	modport sink(input valid, sub_diag, main_diag, super_diag, rhs_lane0, rhs_lane1,
		rhs_lane2, rhs_lane3, output ready);
endinterface

interface tdss_out_if;
	logic valid;
	logic ready;
	logic [5:0] row_index;
	logic signed [31:0] sol_lane0;
	logic signed [31:0] sol_lane1;
	logic signed [31:0] sol_lane2;
	logic signed [31:0] sol_lane3;
	logic pivot_error;
	logic final_row;
	modport source(output valid, row_index, sol_lane0, sol_lane1, sol_lane2, sol_lane3,
		pivot_error, final_row, input ready);
	modport sink(input valid, row_index, sol_lane0, sol_lane1, sol_lane2, sol_lane3,
		pivot_error, final_row, output ready);
endinterface
`default_nettype wire

[hdl/tdss_div.sv]
`default_nettype none
// Restoring divider: (num << FracBits) / den, truncated toward zero, saturated.
module tdss_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tdss_pkg::fx_t num,
	input wire tdss_pkg::fx_t den,
	output logic done,
	output tdss_pkg::fx_t quo
);
	import tdss_pkg::*;
	localparam int NW = 32 + FracBits;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [NW-1:0] q_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic neg_q, zero_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [33:0] trial;
	logic [33:0] shifted;
	logic signed [NW+1:0] sq;

	always_comb begin
		shifted = {rem_q, dvd_q[NW-1]};
		trial = shifted - {2'b0, dvs_q};
		sq = neg_q ? -$signed({2'b0, q_q}) : $signed({2'b0, q_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
				dvd_q <= NW'(num[31] ? 33'(-$signed({num[31], num})) : 33'(num)) << FracBits;
				dvs_q <= den[31] ? 32'(-$signed({den[31], den})) : den;
				rem_q <= '0;
				q_q <= '0;
				neg_q <= num[31] ^ den[31];
				zero_q <= (den == '0);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					dvd_q <= dvd_q << 1;
					if (!trial[33]) begin
						rem_q <= trial[32:0];
						q_q <= {q_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= shifted[32:0];
						q_q <= {q_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done <= 1'b1;
					quo <= zero_q ? '0 : sat32(66'(sq));
				end
			end
		end
	end
endmodule
`default_nettype wire

[hdl/tdss_lane.sv]
`default_nettype none
// One column (a right-hand lane or the upper coefficient): forward numerator, then division.
module tdss_lane (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic first,
	input wire tdss_pkg::fx_t rhs,
	input wire tdss_pkg::fx_t sub,
	input wire tdss_pkg::fx_t prev,
	input wire tdss_pkg::fx_t den,
	output logic done,
	output tdss_pkg::fx_t quo
);
	import tdss_pkg::*;
	fx_t prod_s1;
	fx_t rhs_s1;
	fx_t den_s1;
	logic first_s1, go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_s1 <= 1'b0;
		else go_s1 <= start;
	end
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= fx_mul(sub, prev);
			rhs_s1 <= rhs;
			den_s1 <= den;
			first_s1 <= first;
		end
	end

	tdss_div u_div (.clk(clk), .arst_n(arst_n), .start(go_s1),
		.num(first_s1 ? rhs_s1 : fx_sub(rhs_s1, prod_s1)), .den(den_s1),
		.done(done), .quo(quo));
endmodule
`default_nettype wire

[hdl/tridiagonal_system_solver_unit.sv]
`default_nettype none
// Rows 0..n-2 each take the pivot product, the subtract, then the 48-step restoring
// divider in every lane, with the upper coefficient in a fifth divider. The last row
// does the same; then the solution rows leave from the last to row 0, each after a
// memory read, product, subtract and write back, stalled by the output side.
// Rows are taken one at a time. Reset clears control state, row counter and error
// flag; stores are not cleared, and each entry is written before its value is used.
module tridiagonal_system_solver_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [6:0] cfg_data,
	tdss_in_if.sink in_ch,
	tdss_out_if.source out_ch
);
	import tdss_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PIV, S_DEN, S_DIV, S_BRD, S_BMUL, S_BSUB, S_OUT} st_t;
	st_t st_q;

	logic [6:0] row_count_q;
	logic [2:0] rhs_count_q;
	logic [RowW:0] row_q;
	logic err_q, last_q;
	logic [RowW-1:0] br_q;

	fx_t sub_q, main_q, sup_q;
	lanes_t rhs_q;
	fx_t piv_prod_q, uprev_q;
	fx_t den_next;
	lanes_t yprev_q;

	fx_t upper_mem [MaxRows];
	lanes_t rhs_mem [MaxRows];
	fx_t u_rd_q;
	lanes_t y_rd_q;
	lanes_t x_next_q;
	lanes_t bprod_q;

	logic [RhsLanes:0] done_v;
	logic [RhsLanes:0] done_q;
	fx_t [RhsLanes:0] quo_v;
	lanes_t yq_q;
	fx_t uq_q;
	logic div_go;

	logic [6:0] rows_eff;
	logic [2:0] lanes_eff;
	logic [RowW-1:0] ri;

	always_comb begin
		rows_eff = (row_count_q == 0) ? 7'd1 : (row_count_q > 7'(MaxRows)) ? 7'(MaxRows)
			: row_count_q;
		lanes_eff = (rhs_count_q == 0) ? 3'd1 : (rhs_count_q > 3'(RhsLanes)) ? 3'(RhsLanes)
			: rhs_count_q;
		ri = row_q[RowW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= 7'd64;
			rhs_count_q <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegRowCount: row_count_q <= cfg_data;
				RegRhsCount: rhs_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (st_q == S_IDLE);
	assign div_go = (st_q == S_DEN);
	assign den_next = (row_q == 0) ? main_q : fx_sub(main_q, piv_prod_q);

	for (genvar k = 0; k < RhsLanes; k++) begin : g_lane
		tdss_lane u_lane (.clk(clk), .arst_n(arst_n), .start(div_go), .first(row_q == 0),
			.rhs(rhs_q[k]), .sub(sub_q), .prev(yprev_q[k]), .den(den_next),
			.done(done_v[k]), .quo(quo_v[k]));
	end
	tdss_lane u_upper (.clk(clk), .arst_n(arst_n), .start(div_go), .first(1'b1),
		.rhs(sup_q), .sub(sub_q), .prev(uprev_q), .den(den_next),
		.done(done_v[RhsLanes]), .quo(quo_v[RhsLanes]));

	always_ff @(posedge clk) begin
		if (st_q == S_PIV) begin
			uprev_q <= upper_mem[ri - 1'b1];
			yprev_q <= rhs_mem[ri - 1'b1];
		end
		if (done_v[0]) begin
			for (int k = 0; k < RhsLanes; k++) yq_q[k] <= quo_v[k];
			uq_q <= quo_v[RhsLanes];
		end
		if (st_q == S_DIV && done_q[0]) begin
			rhs_mem[ri] <= yq_q;
			if (!last_q) upper_mem[ri] <= uq_q;
		end
		if (st_q == S_BRD) begin
			u_rd_q <= upper_mem[br_q];
			y_rd_q <= rhs_mem[br_q];
		end
		if (st_q == S_BMUL)
			for (int k = 0; k < RhsLanes; k++) bprod_q[k] <= fx_mul(u_rd_q, x_next_q[k]);
		if (st_q == S_BSUB && !(6'(br_q) == 6'(row_q))) begin
			for (int k = 0; k < RhsLanes; k++) begin
				x_next_q[k] <= fx_sub(y_rd_q[k], bprod_q[k]);
				rhs_mem[br_q][k] <= fx_sub(y_rd_q[k], bprod_q[k]);
			end
		end else if (st_q == S_BSUB) x_next_q <= y_rd_q;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sub_q <= in_ch.sub_diag;
			main_q <= in_ch.main_diag;
			sup_q <= in_ch.super_diag;
			rhs_q <= {in_ch.rhs_lane3, in_ch.rhs_lane2, in_ch.rhs_lane1, in_ch.rhs_lane0};
		end
	end

	logic piv_ready_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			row_q <= '0;
			err_q <= 1'b0;
			last_q <= 1'b0;
			br_q <= '0;
			done_q <= '0;
			piv_ready_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			done_q <= done_v;
			unique case (st_q)
				S_IDLE: if (in_ch.valid) begin
					if (row_q >= (RowW+1)'(MaxRows)) row_q <= (RowW+1)'(MaxRows - 1);
					st_q <= S_PIV;
					piv_ready_q <= 1'b0;
				end
				S_PIV: begin
					last_q <= (7'(row_q) + 7'd1 >= rows_eff);
					if (piv_ready_q) st_q <= S_DEN;
					piv_ready_q <= 1'b1;
				end
				S_DEN: begin
					if (den_next == '0) err_q <= 1'b1;
					st_q <= S_DIV;
				end
				S_DIV: if (done_q[0]) begin
					if (!last_q) begin
						row_q <= row_q + 1'b1;
						st_q <= S_IDLE;
					end else begin
						br_q <= ri;
						st_q <= S_BRD;
					end
				end
				S_BRD: st_q <= S_BMUL;
				S_BMUL: st_q <= S_BSUB;
				S_BSUB: begin
					out_ch.valid <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					if (br_q == '0) begin
						row_q <= '0;
						err_q <= 1'b0;
						st_q <= S_IDLE;
					end else begin
						br_q <= br_q - 1'b1;
						st_q <= S_BRD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// pivot product needs the upper coefficient read in S_PIV
	always_ff @(posedge clk) begin
		if (st_q == S_PIV) piv_prod_q <= fx_mul(sub_q, uprev_q);
	end

	always_comb begin
		out_ch.row_index = 6'(br_q);
		out_ch.sol_lane0 = x_next_q[0];
		out_ch.sol_lane1 = (lanes_eff > 3'd1) ? x_next_q[1] : '0;
		out_ch.sol_lane2 = (lanes_eff > 3'd2) ? x_next_q[2] : '0;
		out_ch.sol_lane3 = (lanes_eff > 3'd3) ? x_next_q[3] : '0;
		out_ch.pivot_error = err_q;
		out_ch.final_row = (br_q == '0);
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("accepting while emitting");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		done_v[0] |-> done_v[RhsLanes]) else $error("dividers out of step");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(br_q))
		else $error("result dropped");
endmodule
`default_nettype wire
